// File: design/packet_sequence_gap_tracker_top_macros.svh
// ---------------------------------------------------------------------------
// Packet sequence gap tracker assertion macros
// Shorthand for the concurrent checks on the tracker's ports.
// ---------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_GAP_TRACKER_TOP_MACROS_SVH
`define PACKET_SEQUENCE_GAP_TRACKER_TOP_MACROS_SVH

// Check that is held off while reset is asserted.
`define PSGT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also applies while reset is asserted.
`define PSGT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/psgt_pkg.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker package
// Item types, verdict codes and sizing constants shared by the tracker.
// ---------------------------------------------------------------------------
package psgt_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] COUNT_HEARTBEAT = 16'h0000;
    localparam logic [15:0] COUNT_END = 16'hFFFF;

    typedef enum logic [2:0] {
        VERDICT_APPLIED   = 3'd0,
        VERDICT_MALFORMED = 3'd1,
        VERDICT_END       = 3'd2,
        VERDICT_HEARTBEAT = 3'd3,
        VERDICT_DUPLICATE = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [15:0] packet_length;
        logic [15:0] session_high;
        logic [63:0] session_low;
        logic [63:0] sequence_number;
        logic [15:0] msg_count;
        logic [15:0] blocks_found;
        logic        payload_consumed;
    } packet_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        gap_found;
        logic [63:0] gap_first;
        logic [63:0] gap_length;
        logic        session_changed;
        logic [15:0] deliver_count;
        logic [63:0] expected_next;
        logic [63:0] last_applied;
        logic        end_seen;
        logic [31:0] gap_events;
        logic [63:0] lost_messages;
    } result_t;

    typedef struct packed {
        logic        short_packet;
        logic        is_end;
        logic        is_heartbeat;
        logic        framing_ok;
        logic [15:0] session_high;
        logic [63:0] session_low;
        logic [63:0] sequence_number;
        logic [15:0] msg_count;
    } work_t;

endpackage

// File: design/psgt_front.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker front end
// Classifies each incoming header on the fields that need no stored state.
// ---------------------------------------------------------------------------
module psgt_front
(
    input  psgt_pkg::packet_t packet,
    output psgt_pkg::work_t   work
);
    import psgt_pkg::*;

    always_comb
    begin
        work.short_packet    = packet.packet_length < 16'(HEADER_BYTES);
        work.is_end          = packet.msg_count == COUNT_END;
        work.is_heartbeat    = packet.msg_count == COUNT_HEARTBEAT;
        work.framing_ok      = packet.payload_consumed
                               && (packet.blocks_found == packet.msg_count);
        work.session_high    = packet.session_high;
        work.session_low     = packet.session_low;
        work.sequence_number = packet.sequence_number;
        work.msg_count       = packet.msg_count;
    end

endmodule

// File: design/psgt_queue.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker queue
// Short first-in first-out buffer of classified items between front and back.
// ---------------------------------------------------------------------------
module psgt_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psgt_pkg::work_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output psgt_pkg::work_t head
);
    import psgt_pkg::*;

    work_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;

    assign full  = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/psgt_back.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker back end
// Holds the session and sequence state, applies one item per cycle while its
// result is not stalled, and registers the result.
// ---------------------------------------------------------------------------
module psgt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_ready,
    input  psgt_pkg::work_t   work,
    output logic              take,
    output logic              result_valid,
    input  logic              result_ready,
    output psgt_pkg::result_t result
);
    import psgt_pkg::*;

    logic        started_reg;
    logic        started_next;
    logic [15:0] session_high_reg;
    logic [15:0] session_high_next;
    logic [63:0] session_low_reg;
    logic [63:0] session_low_next;
    logic [63:0] expected_reg;
    logic [63:0] expected_next;
    logic [63:0] last_reg;
    logic [63:0] last_next;
    logic        end_reg;
    logic        end_next;
    logic [31:0] gap_events_reg;
    logic [31:0] gap_events_next;
    logic [63:0] lost_reg;
    logic [63:0] lost_next;
    logic        valid_reg;
    logic        valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic        session_differs;
    logic        new_session;
    logic [63:0] expected_eff;
    logic        ahead;
    logic        behind;
    logic [63:0] distance;
    logic        gap;
    verdict_t    verdict;
    logic        changed;
    logic [15:0] deliver;

    assign take         = item_ready && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign session_differs = (work.session_high != session_high_reg)
                             || (work.session_low != session_low_reg);
    assign new_session     = !started_reg || session_differs;
    assign expected_eff    = new_session ? work.sequence_number : expected_reg;
    assign ahead           = work.sequence_number > expected_eff;
    assign behind          = work.sequence_number < expected_eff;
    assign distance        = work.sequence_number - expected_eff;

    always_comb
    begin
        started_next      = started_reg;
        session_high_next = session_high_reg;
        session_low_next  = session_low_reg;
        expected_next     = expected_reg;
        last_next         = last_reg;
        end_next          = end_reg;
        gap_events_next   = gap_events_reg;
        lost_next         = lost_reg;
        verdict           = VERDICT_MALFORMED;
        gap               = 1'b0;
        changed           = 1'b0;
        deliver           = '0;

        if (!work.short_packet)
        begin
            started_next      = 1'b1;
            session_high_next = work.session_high;
            session_low_next  = work.session_low;
            expected_next     = expected_eff;
            changed           = started_reg && session_differs;
            if (work.is_end)
            begin
                verdict   = VERDICT_END;
                gap       = ahead;
                end_next  = 1'b1;
                last_next = work.sequence_number;
                if (ahead)
                begin
                    expected_next = work.sequence_number;
                end
            end
            else if (work.is_heartbeat)
            begin
                verdict = VERDICT_HEARTBEAT;
            end
            else if (behind)
            begin
                verdict = VERDICT_DUPLICATE;
            end
            else if (!work.framing_ok)
            begin
                verdict = VERDICT_MALFORMED;
            end
            else
            begin
                verdict       = VERDICT_APPLIED;
                gap           = ahead;
                last_next     = work.sequence_number;
                deliver       = work.msg_count;
                expected_next = work.sequence_number + {48'd0, work.msg_count};
            end
        end

        if (gap)
        begin
            gap_events_next = (gap_events_reg == '1) ? gap_events_reg
                              : gap_events_reg + 1'b1;
            lost_next       = lost_reg + distance;
        end

        result_next.verdict         = verdict;
        result_next.gap_found       = gap;
        result_next.gap_first       = gap ? expected_eff : '0;
        result_next.gap_length      = gap ? distance : '0;
        result_next.session_changed = changed;
        result_next.deliver_count   = deliver;
        result_next.expected_next   = expected_next;
        result_next.last_applied    = last_next;
        result_next.end_seen        = end_next;
        result_next.gap_events      = gap_events_next;
        result_next.lost_messages   = lost_next;

        valid_next = take || (valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            session_high_reg <= '0;
            session_low_reg  <= '0;
            expected_reg     <= '0;
            last_reg         <= '0;
            end_reg          <= 1'b0;
            gap_events_reg   <= '0;
            lost_reg         <= '0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                started_reg      <= started_next;
                session_high_reg <= session_high_next;
                session_low_reg  <= session_low_next;
                expected_reg     <= expected_next;
                last_reg         <= last_next;
                end_reg          <= end_next;
                gap_events_reg   <= gap_events_next;
                lost_reg         <= lost_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: design/packet_sequence_gap_tracker_top.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker
// Checks packet headers for session changes, duplicates, framing errors and
// sequence gaps, and reports one result item per packet item.
//
//   Channel   Handshake                    Payload
//   packet    packet_valid / packet_ready  packet (psgt_pkg::packet_t)
//   result    result_valid / result_ready  result (psgt_pkg::result_t)
//
// One item per cycle is sustained while results are not stalled; the back end
// updates its state as it takes each item.
// A packet item is written into the queue, and its result item is registered
// in the back end when the back end takes it from the queue.
// The four-entry queue lets packets keep arriving while results are stalled.
// Reset clears all session and sequence state and empties the queue.
// ---------------------------------------------------------------------------
module packet_sequence_gap_tracker_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              packet_valid,
    output logic              packet_ready,
    input  psgt_pkg::packet_t packet,
    output logic              result_valid,
    input  logic              result_ready,
    output psgt_pkg::result_t result
);
    import psgt_pkg::*;

    work_t front_work;
    work_t queue_head;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  take;

    assign packet_ready = !queue_full;
    assign push         = packet_valid && packet_ready;

    psgt_front u_front
    (
        .packet (packet),
        .work   (front_work)
    );

    psgt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_work),
        .full      (queue_full),
        .pop       (take),
        .empty     (queue_empty),
        .head      (queue_head)
    );

    psgt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ready   (!queue_empty),
        .work         (queue_head),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: design/psgt_checker.sv
// ---------------------------------------------------------------------------
// Packet sequence gap tracker checker
// Port-level checks on result items, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "packet_sequence_gap_tracker_top_macros.svh"

module psgt_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input psgt_pkg::result_t result
);
    import psgt_pkg::*;

    `PSGT_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid && $stable(result), "Stalled result item changed or dropped.")

    `PSGT_ASSERT(a_deliver_only_applied, result_valid && result.verdict != VERDICT_APPLIED |-> result.deliver_count == 16'd0, "Messages delivered for a packet that was not applied.")

    `PSGT_ASSERT(a_gap_fields_clear, result_valid && !result.gap_found |-> result.gap_first == 64'd0 && result.gap_length == 64'd0, "Gap fields set without a gap.")

    `PSGT_ASSERT(a_end_flag, result_valid && result.verdict == VERDICT_END |-> result.end_seen, "End of session not reflected in state.")

    `PSGT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !result_valid, "Result item valid during reset.")

endmodule

bind packet_sequence_gap_tracker_top psgt_checker u_psgt_checker (.*);

// File: tb/packet_gap_verdict_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Packet gap verdict check
// Watches both channels of the sequence gap tracker and keeps its own copy of
// the session, sequence and loss state. Each accepted packet item yields one
// expected result item. Each accepted result item is compared field by field
// with the oldest expected one, and every mismatch is counted for the top.
// ---------------------------------------------------------------------------
module packet_gap_verdict_check
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              packet_valid,
    input  logic              packet_ready,
    input  psgt_pkg::packet_t packet,
    input  logic              result_valid,
    input  logic              result_ready,
    input  psgt_pkg::result_t result,
    output int                mismatch_count,
    output int                outstanding,
    output int                results_checked,
    output int                gaps_reported
);
    import psgt_pkg::*;

    localparam int MAX_REPORTS = 40;

    logic        session_open;
    logic [15:0] held_session_high;
    logic [63:0] held_session_low;
    logic [63:0] next_seq;
    logic [63:0] last_seq;
    logic        session_ended;
    logic [31:0] gap_tally;
    logic [63:0] lost_tally;

    result_t pending_results[$];
    result_t want_result;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $realtime, results_checked, field, got, want);
        mismatch_count++;
    endtask

    function automatic void log_gap(inout result_t r, input logic [63:0] from,
                                    input logic [63:0] span);
        r.gap_found = 1'b1;
        r.gap_first = from;
        r.gap_length = span;
        if (gap_tally != '1)
            gap_tally++;
        lost_tally += span;
    endfunction

    function automatic result_t track_packet(input packet_t p);
        result_t r;
        r = '0;
        r.verdict = VERDICT_MALFORMED;
        if (p.packet_length >= HEADER_BYTES)
        begin
            if (!session_open || p.session_high != held_session_high
                || p.session_low != held_session_low)
            begin
                r.session_changed = session_open;
                session_open = 1'b1;
                held_session_high = p.session_high;
                held_session_low = p.session_low;
                next_seq = p.sequence_number;
            end
            if (p.msg_count == COUNT_END)
            begin
                if (p.sequence_number > next_seq)
                begin
                    log_gap(r, next_seq, p.sequence_number - next_seq);
                    next_seq = p.sequence_number;
                end
                session_ended = 1'b1;
                last_seq = p.sequence_number;
                r.verdict = VERDICT_END;
            end
            else if (p.msg_count == COUNT_HEARTBEAT)
            begin
                r.verdict = VERDICT_HEARTBEAT;
            end
            else if (p.sequence_number < next_seq)
            begin
                r.verdict = VERDICT_DUPLICATE;
            end
            else if (!p.payload_consumed || p.blocks_found != p.msg_count)
            begin
                r.verdict = VERDICT_MALFORMED;
            end
            else
            begin
                if (p.sequence_number > next_seq)
                    log_gap(r, next_seq, p.sequence_number - next_seq);
                last_seq = p.sequence_number;
                r.deliver_count = p.msg_count;
                next_seq = p.sequence_number + 64'(p.msg_count);
                r.verdict = VERDICT_APPLIED;
            end
        end
        r.expected_next = next_seq;
        r.last_applied = last_seq;
        r.end_seen = session_ended;
        r.gap_events = gap_tally;
        r.lost_messages = lost_tally;
        return r;
    endfunction

    task automatic check_result(input result_t got, input result_t want);
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
        if (got.gap_found !== want.gap_found)
            report_mismatch("gap_found", 64'(got.gap_found), 64'(want.gap_found));
        if (got.gap_first !== want.gap_first)
            report_mismatch("gap_first", got.gap_first, want.gap_first);
        if (got.gap_length !== want.gap_length)
            report_mismatch("gap_length", got.gap_length, want.gap_length);
        if (got.session_changed !== want.session_changed)
            report_mismatch("session_changed", 64'(got.session_changed),
                            64'(want.session_changed));
        if (got.deliver_count !== want.deliver_count)
            report_mismatch("deliver_count", 64'(got.deliver_count),
                            64'(want.deliver_count));
        if (got.expected_next !== want.expected_next)
            report_mismatch("expected_next", got.expected_next, want.expected_next);
        if (got.last_applied !== want.last_applied)
            report_mismatch("last_applied", got.last_applied, want.last_applied);
        if (got.end_seen !== want.end_seen)
            report_mismatch("end_seen", 64'(got.end_seen), 64'(want.end_seen));
        if (got.gap_events !== want.gap_events)
            report_mismatch("gap_events", 64'(got.gap_events), 64'(want.gap_events));
        if (got.lost_messages !== want.lost_messages)
            report_mismatch("lost_messages", got.lost_messages, want.lost_messages);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_open <= 1'b0;
            held_session_high <= '0;
            held_session_low <= '0;
            next_seq <= '0;
            last_seq <= '0;
            session_ended <= 1'b0;
            gap_tally <= '0;
            lost_tally <= '0;
            pending_results.delete();
            outstanding <= 0;
            mismatch_count = 0;
            results_checked = 0;
            gaps_reported = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("item with nothing expected", 64'(result.verdict), 0);
                end
                else
                begin
                    want_result = pending_results.pop_front();
                    check_result(result, want_result);
                    if (want_result.gap_found)
                        gaps_reported++;
                    results_checked++;
                end
            end
            if (packet_valid && packet_ready)
                pending_results.insert(pending_results.size(), track_packet(packet));
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: tb/packet_sequence_gap_tracker_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Packet sequence gap tracker testbench
// Drives packet header items into the tracker, first a directed run through
// short packets, session changes, heartbeats, duplicates, framing errors,
// ends of session and sequence wrap, then mostly well-formed random streams
// mixed with broken and random items. Sender and receiver pacing changes over
// three phases, and a separate check module predicts and compares results.
// ---------------------------------------------------------------------------
module packet_sequence_gap_tracker_top_test;
    import psgt_pkg::*;

    localparam int RANDOM_PER_PHASE = 184;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic    clk;
    logic    rst_n;
    logic    packet_valid;
    logic    packet_ready;
    packet_t packet;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int gaps_reported;
    int items_sent;
    int stall_cycles;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    logic [15:0] stream_high;
    logic [63:0] stream_low;
    logic [63:0] stream_seq;

    packet_sequence_gap_tracker_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .packet_valid (packet_valid),
        .packet_ready (packet_ready),
        .packet       (packet),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    packet_gap_verdict_check u_verdict_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .packet_valid    (packet_valid),
        .packet_ready    (packet_ready),
        .packet          (packet),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .gaps_reported   (gaps_reported)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic packet_t header_item(input logic [15:0] len,
                                            input logic [15:0] s_high,
                                            input logic [63:0] s_low,
                                            input logic [63:0] seq,
                                            input logic [15:0] cnt,
                                            input logic [15:0] blocks,
                                            input logic consumed);
        packet_t p;
        p.packet_length = len;
        p.session_high = s_high;
        p.session_low = s_low;
        p.sequence_number = seq;
        p.msg_count = cnt;
        p.blocks_found = blocks;
        p.payload_consumed = consumed;
        return p;
    endfunction

    task automatic send_packet(input packet_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            packet_valid <= 1'b0;
            @(posedge clk);
        end
        packet_valid <= 1'b1;
        packet <= p;
        @(posedge clk);
        while (!packet_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic next_random_packet(output packet_t p);
        int unsigned pick;
        int unsigned mode;
        logic [15:0] cnt;
        logic [15:0] len;
        logic [63:0] seq;
        pick = $urandom_range(99);
        cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(65534, 1))
                                       : 16'($urandom_range(24, 1));
        len = ($urandom_range(7) == 0) ? 16'(HEADER_BYTES)
                                       : 16'($urandom_range(65535, HEADER_BYTES));
        seq = stream_seq;
        if (pick < 10)
        begin
            seq = ($urandom_range(7) == 0) ? stream_seq + rand64()
                                           : stream_seq + 64'($urandom_range(500, 1));
        end
        else if (pick < 16)
        begin
            seq = stream_seq - 64'($urandom_range(300, 1));
        end
        else if (pick < 26)
        begin
            mode = $urandom_range(2);
            if (mode != 1)
                stream_high = 16'($urandom);
            if (mode != 0)
                stream_low = rand64();
            mode = $urandom_range(2);
            if (mode == 0)
                seq = rand64();
            else if (mode == 1)
                seq = 64'($urandom_range(1000));
            else
                seq = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(255));
        end
        p = header_item(len, stream_high, stream_low, seq, cnt, cnt, 1'b1);
        if (pick < 16)
        begin
            if (seq >= stream_seq)
                stream_seq = seq + 64'(cnt);
        end
        else if (pick < 62)
        begin
            stream_seq = seq + 64'(cnt);
        end
        else if (pick < 68)
        begin
            p.msg_count = COUNT_HEARTBEAT;
            p.sequence_number = rand64();
            p.blocks_found = 16'($urandom);
            p.payload_consumed = 1'($urandom);
        end
        else if (pick < 76)
        begin
            if ($urandom_range(1) == 0)
                p.payload_consumed = 1'b0;
            else
                p.blocks_found = cnt ^ 16'($urandom_range(65535, 1));
        end
        else if (pick < 81)
        begin
            p.sequence_number = stream_seq + 64'($urandom_range(20)) - 64'd5;
            p.msg_count = COUNT_END;
            p.blocks_found = 16'($urandom);
            p.payload_consumed = 1'($urandom);
            if (p.sequence_number > stream_seq)
                stream_seq = p.sequence_number;
        end
        else if (pick < 91)
        begin
            p = header_item(16'($urandom_range(HEADER_BYTES - 1)), 16'($urandom), rand64(),
                            rand64(), 16'($urandom), 16'($urandom), 1'($urandom));
        end
        else
        begin
            p = header_item(16'($urandom), 16'($urandom), rand64(), rand64(),
                            16'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (packet_valid && packet_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
                break;
        end
        $display("Timed out after %0d cycles with no item accepted.", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        packet_t p;
        logic [63:0] all_ones;
        all_ones = '1;
        items_sent = 0;
        send_idle_pct = 19;
        recv_idle_pct = 81;
        stream_high = '0;
        stream_low = '0;
        stream_seq = '0;
        rst_n <= 1'b0;
        packet_valid <= 1'b0;
        packet <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_packet(header_item(16'd0, 16'hFFFF, all_ones, all_ones, 16'd5, 16'd5, 1'b1));
        send_packet(header_item(16'(HEADER_BYTES - 1), 16'd0, 64'd0, 64'd7, 16'd1, 16'd1,
                                1'b1));
        send_packet(header_item(16'(HEADER_BYTES), 16'd0, 64'd0, 64'd100, 16'd3, 16'd3,
                                1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd500, COUNT_HEARTBEAT, 16'd0,
                                1'b0));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd103, 16'd1, 16'd1, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd110, 16'd2, 16'd2, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd50, 16'd1, 16'd1, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd112, 16'd2, 16'd2, 1'b0));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd112, 16'd2, 16'd3, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd112, 16'd2, 16'd2, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd120, COUNT_END, 16'd0, 1'b0));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd90, COUNT_END, 16'd7, 1'b1));
        send_packet(header_item(16'd64, 16'd0, 64'd0, 64'd120, 16'd4, 16'd4, 1'b1));
        send_packet(header_item(16'(HEADER_BYTES), 16'd1, 64'd0, 64'd1000, 16'd5, 16'd4,
                                1'b1));
        send_packet(header_item(16'd200, 16'd1, 64'd0, 64'd1000, 16'd5, 16'd5, 1'b1));
        send_packet(header_item(16'd200, 16'd1, 64'd1, 64'd7, COUNT_HEARTBEAT, 16'd0,
                                1'b1));
        send_packet(header_item(16'd200, 16'hFFFF, all_ones, 64'hFFFF_FFFF_FFFF_FFFE,
                                16'd5, 16'd5, 1'b1));
        send_packet(header_item(16'd200, 16'hFFFF, all_ones, 64'd3, 16'd1, 16'd1, 1'b1));
        send_packet(header_item(16'hFFFF, 16'hFFFF, all_ones, all_ones, 16'hFFFE,
                                16'hFFFE, 1'b1));
        send_packet(header_item(16'hFFFF, 16'hFFFF, all_ones, all_ones, COUNT_END,
                                16'hFFFF, 1'b1));
        send_packet(header_item(16'd1000, 16'hFFFF, all_ones, 64'h10, COUNT_END, 16'd0,
                                1'b0));
        send_packet(header_item(16'(HEADER_BYTES), 16'hFFFF, all_ones, 64'd0, 16'd1,
                                16'd1, 1'b1));

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 19;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                next_random_packet(p);
                send_packet(p);
            end
        end

        packet_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d packet items under sender stalls, receiver stalls and full rate.",
                 items_sent);
        $display("Compared %0d result items; %0d of them reported a sequence gap.",
                 results_checked, gaps_reported);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/psgt_pkg.sv
design/psgt_front.sv
design/psgt_queue.sv
design/psgt_back.sv
design/packet_sequence_gap_tracker_top.sv
design/psgt_checker.sv
tb/packet_gap_verdict_check.sv
tb/packet_sequence_gap_tracker_top_test.sv
